### hdl/tws_pkg.sv
// Shared types and constants for the two-wire display serial master.
`timescale 1ns / 1ps

package tws_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

    // Command codes double as the sequencer state; idle is the rest state.
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    // One classified tick as it travels from the front end to the sequencer.
    typedef struct packed {
        logic       is_cmd;
        cmd_t       cmd;
        logic [7:0] data;
        logic       dio_in;
    } tws_item_t;

    // One result of the sequencer.
    typedef struct packed {
        logic       rejected;
        logic [7:0] read_byte;
        logic       ack_bit;
        logic       done_res;
        logic       busy_res;
        logic       dio_drive;
        logic       dio_level;
        logic       clk_level;
    } tws_result_t;

endpackage

### hdl/tws_front.sv
// Front end: classifies incoming ticks and buffers them in a short queue.
`timescale 1ns / 1ps

module tws_front
    import tws_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [2:0] s_tuser,
    input  logic [7:0] s_data,
    input  logic       s_dio_in,
    output logic       q_valid,
    output tws_item_t  q_item,
    input  logic       q_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tws_item_t          queue_mem [DEPTH];
    tws_item_t          item_in;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;

    // Only the four defined command codes count; the other codes act as no command.
    always_comb
    begin
        item_in.data   = s_data;
        item_in.dio_in = s_dio_in;
        item_in.cmd    = CMD_IDLE;
        item_in.is_cmd = 1'b0;
        unique case (s_tuser) inside
            CMD_START, CMD_WRITE, CMD_READ, CMD_STOP:
            begin
                item_in.cmd    = cmd_t'(s_tuser);
                item_in.is_cmd = 1'b1;
            end
            default:
            begin
                item_in.cmd    = CMD_IDLE;
                item_in.is_cmd = 1'b0;
            end
        endcase
    end

    assign s_tready = (count_reg != FULL_CNT);
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### hdl/tws_back.sv
// Back end: pin phase sequencer with a registered result stage.
`timescale 1ns / 1ps

module tws_back
    import tws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        q_valid,
    input  tws_item_t   q_item,
    output logic        q_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output tws_result_t m_result
);

    logic [15:0]  half_period_reg;
    logic [15:0]  tick_reg, tick_next;
    cmd_t         cmd_reg, cmd_next;
    logic [2:0]   phase_reg, phase_next;
    logic [3:0]   bit_reg, bit_next;
    logic [7:0]   shift_out_reg, shift_out_next;
    logic [7:0]   shift_in_reg, shift_in_next;
    logic         ack_reg, ack_next;
    logic         pin_clk_reg, pin_clk_next;
    logic         pin_dio_reg, pin_dio_next;
    logic         pin_drive_reg, pin_drive_next;
    logic         out_valid_reg;
    tws_result_t  out_reg, out_next;

    logic [15:0]  hp;
    logic [15:0]  tick_inc;
    logic [2:0]   phase_inc;
    logic [3:0]   bit_inc;
    logic [2:0]   phase_count;
    logic [3:0]   slot_count;
    logic         step;
    logic         enter;
    logic         leave;
    logic         launch;
    logic         done;
    logic         rejected;

    assign q_ready  = !out_valid_reg || m_tready;
    assign step     = q_valid && q_ready;
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    assign hp        = (half_period_reg == '0) ? 16'd1 : half_period_reg;
    assign tick_inc  = tick_reg + 16'd1;
    assign phase_inc = phase_reg + 3'd1;
    assign bit_inc   = bit_reg + 4'd1;

    always_comb
    begin
        unique case (cmd_reg)
            CMD_START: phase_count = 3'd5;
            CMD_STOP:  phase_count = 3'd4;
            CMD_WRITE: phase_count = (bit_reg < 4'(BITS_PER_BYTE)) ? 3'd4 : 3'd3;
            default:   phase_count = 3'd3;
        endcase
        unique case (cmd_reg)
            CMD_WRITE, CMD_READ: slot_count = 4'(BITS_PER_BYTE + 1);
            default:             slot_count = 4'd1;
        endcase
    end

    // Next state: phase and bit counters, command completion.
    always_comb
    begin
        tick_next  = tick_reg;
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        enter      = 1'b0;
        leave      = 1'b0;
        launch     = 1'b0;
        done       = 1'b0;
        rejected   = 1'b0;
        unique case (cmd_reg)
            CMD_IDLE:
            begin
                if (q_item.is_cmd)
                begin
                    cmd_next   = q_item.cmd;
                    tick_next  = '0;
                    phase_next = '0;
                    bit_next   = '0;
                    launch     = 1'b1;
                    enter      = 1'b1;
                end
            end
            default:
            begin
                rejected = q_item.is_cmd;
                if (tick_inc >= hp)
                begin
                    tick_next = '0;
                    leave     = (phase_reg == 3'd1);
                    enter     = 1'b1;
                    if (phase_inc >= phase_count)
                    begin
                        phase_next = '0;
                        if (bit_inc >= slot_count)
                        begin
                            bit_next = '0;
                            cmd_next = CMD_IDLE;
                            done     = 1'b1;
                            enter    = 1'b0;
                        end
                        else
                        begin
                            bit_next = bit_inc;
                        end
                    end
                    else
                    begin
                        phase_next = phase_inc;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
        endcase
    end

    // Outputs: shift registers loaded on launch, pin levels on phase entry, samples on leaving a wait phase.
    always_comb
    begin
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        ack_next       = ack_reg;
        pin_clk_next   = pin_clk_reg;
        pin_dio_next   = pin_dio_reg;
        pin_drive_next = pin_drive_reg;

        if (launch && q_item.cmd == CMD_WRITE)
        begin
            shift_out_next = q_item.data;
        end
        if (launch && q_item.cmd == CMD_READ)
        begin
            shift_in_next = '0;
        end

        if (leave)
        begin
            if (cmd_reg == CMD_WRITE && bit_reg >= 4'(BITS_PER_BYTE))
            begin
                ack_next = q_item.dio_in;
            end
            else if (cmd_reg == CMD_READ && bit_reg < 4'(BITS_PER_BYTE))
            begin
                shift_in_next[bit_reg[2:0]] = shift_in_reg[bit_reg[2:0]] | q_item.dio_in;
            end
        end

        if (enter)
        begin
            if (cmd_next == CMD_START)
            begin
                case (phase_next)
                    3'd0:
                    begin
                        pin_drive_next = 1'b1;
                        pin_clk_next   = 1'b1;
                    end
                    3'd1:    pin_dio_next = 1'b1;
                    3'd2:    pin_dio_next = 1'b0;
                    3'd4:    pin_clk_next = 1'b0;
                    default: ;
                endcase
            end
            else if (cmd_next == CMD_STOP)
            begin
                case (phase_next)
                    3'd0:
                    begin
                        pin_drive_next = 1'b1;
                        pin_dio_next   = 1'b0;
                    end
                    3'd1:    pin_clk_next = 1'b0;
                    3'd2:    pin_clk_next = 1'b1;
                    3'd3:    pin_dio_next = 1'b1;
                    default: ;
                endcase
            end
            else if (cmd_next == CMD_WRITE && bit_next < 4'(BITS_PER_BYTE))
            begin
                case (phase_next)
                    3'd0:
                    begin
                        pin_drive_next = 1'b1;
                        pin_clk_next   = 1'b0;
                    end
                    3'd1:    pin_dio_next = shift_out_next[bit_next[2:0]];
                    3'd2:    pin_clk_next = 1'b1;
                    3'd3:    pin_clk_next = 1'b0;
                    default: ;
                endcase
            end
            else
            begin
                // Receive slot: an acknowledge or one read bit.
                case (phase_next)
                    3'd0:
                    begin
                        pin_drive_next = 1'b0;
                        pin_clk_next   = 1'b1;
                    end
                    3'd2:    pin_clk_next = 1'b0;
                    default: ;
                endcase
            end
        end

        out_next.clk_level = pin_clk_next;
        out_next.dio_level = pin_dio_next;
        out_next.dio_drive = pin_drive_next;
        out_next.busy_res  = (cmd_next != CMD_IDLE);
        out_next.done_res  = done;
        out_next.ack_bit   = ack_next;
        out_next.read_byte = shift_in_next;
        out_next.rejected  = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            tick_reg        <= '0;
            cmd_reg         <= CMD_IDLE;
            phase_reg       <= '0;
            bit_reg         <= '0;
            shift_out_reg   <= '0;
            shift_in_reg    <= '0;
            ack_reg         <= 1'b0;
            pin_clk_reg     <= 1'b1;
            pin_dio_reg     <= 1'b1;
            pin_drive_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                half_period_reg <= cfg_wdata;
            end
            if (step)
            begin
                tick_reg      <= tick_next;
                cmd_reg       <= cmd_next;
                phase_reg     <= phase_next;
                bit_reg       <= bit_next;
                shift_out_reg <= shift_out_next;
                shift_in_reg  <= shift_in_next;
                ack_reg       <= ack_next;
                pin_clk_reg   <= pin_clk_next;
                pin_dio_reg   <= pin_dio_next;
                pin_drive_reg <= pin_drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### hdl/two_wire_display_serial_master.sv
// Top level of the two-wire display serial master: front queue and pin sequencer.
//
// Channel   Direction  Handshake             Content
// s_*       in         s_tvalid / s_tready   one tick: command code, data byte, sampled dio
// m_*       out        m_tvalid / m_tready   one result per tick: pins, status, ack, read byte
// cfg_*     in         cfg_wen               half_period register, ticks per pin phase
//
// One transaction is taken per clock cycle while s_tready is high; each yields one result
// transaction, registered first in the queue and then in the sequencer register.
// The queue holds QUEUE_DEPTH transactions, so the input side keeps flowing while
// a result waits; at full queue s_tready drops until the output side drains.
// Reset puts the pins at clock high, data high, released, with no command active.
`timescale 1ns / 1ps

module two_wire_display_serial_master
    import tws_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data, [8] dio_in, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] clk_level, [1] dio_level, [2] dio_drive,
                                   // [3] busy_res, [4] done_res, [5] ack_bit,
                                   // [13:6] read_byte, [14] rejected, [15] zero
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);

    logic        q_valid;
    logic        q_ready;
    tws_item_t   q_item;
    tws_result_t result;

    tws_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_data   (s_tdata[7:0]),
        .s_dio_in (s_tdata[8]),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready)
    );

    tws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_ready   (q_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {1'b0, result.rejected, result.read_byte, result.ack_bit,
                      result.done_res, result.busy_res, result.dio_drive,
                      result.dio_level, result.clk_level};

    // A finishing transaction never reports the sequencer as still busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |-> !m_tdata[3])
        else $error("done reported together with busy");

    // Back-pressure on the input only happens while the queue holds transactions.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("input stalled with an empty queue");

    // A result that is held back must not be overwritten by a new step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !q_ready)
        else $error("sequencer stepped while its result was stalled");

endmodule
